// File: sv/acfh_pkg.sv
// Package for the addressed arm command frame handler.
// Holds item, config and response types plus the fixed codes.
// No dependencies.
`default_nettype none

package acfh_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // event kinds on the receive side
    localparam logic EV_BYTE    = 1'b0;
    localparam logic EV_TIMEOUT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISARM  = 3'd5;

    // register reset values
    localparam logic [7:0] RST_STATION = 8'd1;
    localparam logic [7:0] RST_SYNC    = 8'd170;
    localparam logic [7:0] RST_ACK     = 8'd6;
    localparam logic [7:0] RST_NACK    = 8'd21;
    localparam logic [7:0] RST_ARM     = 8'd1;
    localparam logic [7:0] RST_DISARM  = 8'd2;

    // byte positions inside a response
    localparam logic [BYTE_IDX_W-1:0] POS_SYNC    = 3'd0;
    localparam logic [BYTE_IDX_W-1:0] POS_STATION = 3'd1;
    localparam logic [BYTE_IDX_W-1:0] POS_STATUS  = 3'd2;
    localparam logic [BYTE_IDX_W-1:0] POS_SEQ     = 3'd3;
    localparam logic [BYTE_IDX_W-1:0] POS_CHECK   = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_SEQ  = 3'd3,
        PH_CHK  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       arm_level;
    } out_item_t;

    typedef struct packed {
        logic [7:0] station_addr;
        logic [7:0] sync_value;
        logic [7:0] ack_code;
        logic [7:0] nack_code;
        logic [7:0] arm_code;
        logic [7:0] disarm_code;
    } cfg_t;

    // one queued response
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] seq;
        logic       arm;
    } resp_t;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// File: sv/acfh_parser.sv
// Front end: frame parser, check and command decode, arm state.
// Pushes one response descriptor per answered frame. Uses acfh_pkg.
`default_nettype none

module acfh_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire acfh_pkg::cfg_t    cfg,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire acfh_pkg::in_item_t in_item,
    input  wire acfh_pkg::q_stat_t q_stat,
    output logic                   push,
    output acfh_pkg::resp_t        push_data
);

    acfh_pkg::phase_t phase_reg, phase_next;
    logic             arm_reg, arm_next;
    logic [7:0]       addr_reg;
    logic [7:0]       cmd_reg;
    logic [7:0]       seq_reg;
    logic [7:0]       chk_reg;
    logic             accept;
    logic             is_byte;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign is_byte  = (in_item.cmd == acfh_pkg::EV_BYTE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= acfh_pkg::PH_HUNT;
            arm_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            arm_reg   <= arm_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept && is_byte) begin
            case (phase_reg)
                acfh_pkg::PH_ADDR:
                begin
                    addr_reg <= in_item.rx_byte;
                    chk_reg  <= chk_reg ^ in_item.rx_byte;
                end
                acfh_pkg::PH_CMD:
                begin
                    cmd_reg <= in_item.rx_byte;
                    chk_reg <= chk_reg ^ in_item.rx_byte;
                end
                acfh_pkg::PH_SEQ:
                begin
                    seq_reg <= in_item.rx_byte;
                    chk_reg <= chk_reg ^ in_item.rx_byte;
                end
                acfh_pkg::PH_CHK:
                begin
                end
                default:
                begin
                    // check restarts from the sync byte itself
                    chk_reg <= in_item.rx_byte;
                end
            endcase
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        arm_next         = arm_reg;
        push             = 1'b0;
        push_data.status = cfg.nack_code;
        push_data.seq    = seq_reg;
        if (accept) begin
            if (!is_byte) begin
                phase_next = acfh_pkg::PH_HUNT;
            end else begin
                case (phase_reg)
                    acfh_pkg::PH_ADDR: phase_next = acfh_pkg::PH_CMD;
                    acfh_pkg::PH_CMD:  phase_next = acfh_pkg::PH_SEQ;
                    acfh_pkg::PH_SEQ:  phase_next = acfh_pkg::PH_CHK;
                    acfh_pkg::PH_CHK:
                    begin
                        phase_next = acfh_pkg::PH_HUNT;
                        if (addr_reg == cfg.station_addr) begin
                            push = 1'b1;
                            if (in_item.rx_byte != chk_reg) begin
                                push_data.status = cfg.nack_code;
                            end else if (cmd_reg == cfg.arm_code) begin
                                arm_next         = 1'b1;
                                push_data.status = cfg.ack_code;
                            end else if (cmd_reg == cfg.disarm_code) begin
                                arm_next         = 1'b0;
                                push_data.status = cfg.ack_code;
                            end
                        end
                    end
                    default:
                    begin
                        if (in_item.rx_byte == cfg.sync_value) begin
                            phase_next = acfh_pkg::PH_ADDR;
                        end else begin
                            phase_next = acfh_pkg::PH_HUNT;
                        end
                    end
                endcase
            end
        end
        push_data.arm = arm_next;
    end

endmodule

`default_nettype wire

// File: sv/acfh_queue.sv
// Short response descriptor queue between parser and transmitter.
// Register file with head read; uses acfh_pkg.
`default_nettype none

module acfh_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire acfh_pkg::resp_t   push_data,
    input  wire logic              pop,
    output acfh_pkg::resp_t        head,
    output acfh_pkg::q_stat_t      q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    acfh_pkg::resp_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == FULL_CNT);
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/acfh_tx.sv
// Back end: serializes each queued response into five bytes.
// Output register on the result channel; uses acfh_pkg.
`default_nettype none

module acfh_tx (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire acfh_pkg::cfg_t     cfg,
    input  wire acfh_pkg::q_stat_t  q_stat,
    input  wire acfh_pkg::resp_t    head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output acfh_pkg::out_item_t     out_item
);

    localparam logic [acfh_pkg::BYTE_IDX_W-1:0] LAST_POS = acfh_pkg::POS_CHECK;

    logic                            valid_reg;
    acfh_pkg::out_item_t             item_reg;
    logic [acfh_pkg::BYTE_IDX_W-1:0] idx_reg;
    logic                            load;
    logic                            step;
    logic [7:0]                      byte_sel;

    assign load      = !valid_reg || !out_stall;
    assign step      = load && !q_stat.empty;
    assign pop       = step && (idx_reg == LAST_POS);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        case (idx_reg)
            acfh_pkg::POS_SYNC:    byte_sel = cfg.sync_value;
            acfh_pkg::POS_STATION: byte_sel = cfg.station_addr;
            acfh_pkg::POS_STATUS:  byte_sel = head.status;
            acfh_pkg::POS_SEQ:     byte_sel = head.seq;
            default:               byte_sel = cfg.sync_value ^ cfg.station_addr
                                              ^ head.status ^ head.seq;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= !q_stat.empty;
            end
            if (step) begin
                idx_reg <= (idx_reg == LAST_POS) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (step) begin
            item_reg.tx_byte   <= byte_sel;
            item_reg.last_byte <= (idx_reg == LAST_POS);
            item_reg.arm_level <= head.arm;
        end
    end

endmodule

`default_nettype wire

// File: sv/addressed_arm_command_frame_handler.sv
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  in_item  (cmd, rx_byte)
// out       out  out_valid/ out_stall out_item (tx_byte, last_byte, arm_level)
// cfg       in   cfg_write            cfg_index, cfg_data
//
// One input item per cycle; a frame's response is queued with its check byte,
// then registered in the output byte register and sent one byte per cycle,
// so throughput is one item per cycle on each side while neither side stalls.
// The descriptor queue (QUEUE_DEPTH entries) lets the parser run on while the
// output is stalled; in_stall rises only when the queue is full.
// Reset is asynchronous, active low; registers take their documented values.
// Top level; uses acfh_pkg, acfh_parser, acfh_queue, acfh_tx.
`default_nettype none

module addressed_arm_command_frame_handler #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire acfh_pkg::in_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output acfh_pkg::out_item_t                      out_item,
    input  wire logic                                cfg_write,
    input  wire logic [acfh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [acfh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    acfh_pkg::cfg_t    cfg_reg;
    acfh_pkg::q_stat_t q_stat;
    acfh_pkg::resp_t   push_data;
    acfh_pkg::resp_t   head;
    logic              q_push;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.station_addr <= acfh_pkg::RST_STATION;
            cfg_reg.sync_value   <= acfh_pkg::RST_SYNC;
            cfg_reg.ack_code     <= acfh_pkg::RST_ACK;
            cfg_reg.nack_code    <= acfh_pkg::RST_NACK;
            cfg_reg.arm_code     <= acfh_pkg::RST_ARM;
            cfg_reg.disarm_code  <= acfh_pkg::RST_DISARM;
        end else if (cfg_write) begin
            case (cfg_index)
                acfh_pkg::REG_STATION: cfg_reg.station_addr <= cfg_data;
                acfh_pkg::REG_SYNC:    cfg_reg.sync_value   <= cfg_data;
                acfh_pkg::REG_ACK:     cfg_reg.ack_code     <= cfg_data;
                acfh_pkg::REG_NACK:    cfg_reg.nack_code    <= cfg_data;
                acfh_pkg::REG_ARM:     cfg_reg.arm_code     <= cfg_data;
                acfh_pkg::REG_DISARM:  cfg_reg.disarm_code  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    acfh_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (push_data)
    );

    acfh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    acfh_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("response queue overflow");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("response queue underflow");

    // all bytes of one response carry the same arm level
    a_arm_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_item.last_byte)
        |=> (!out_valid || (out_item.arm_level == $past(out_item.arm_level))))
        else $error("arm level changed inside a response");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for addressed_arm_command_frame_handler.
// Sends receive items and register writes, predicts every response byte and
// checks each output item in order. Needs acfh_pkg and the block's RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 60;
    localparam int CYCLE_LIMIT   = 200000;

    // indexes past the end of the register list; writes there do nothing
    localparam logic [acfh_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [acfh_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    acfh_pkg::in_item_t                   in_item;
    logic                                 out_valid;
    logic                                 out_stall;
    acfh_pkg::out_item_t                  out_item;
    logic                                 cfg_write;
    logic [acfh_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [acfh_pkg::CFG_DATA_W-1:0]      cfg_data;

    // frame parser mirror
    acfh_pkg::cfg_t       cfg_model;
    acfh_pkg::phase_t     rx_phase;
    logic [7:0]           rx_addr;
    logic [7:0]           rx_cmd;
    logic [7:0]           rx_seq;
    logic [7:0]           rx_xor;
    logic                 arm_model;
    acfh_pkg::out_item_t  reply_bytes_due[$];
    acfh_pkg::out_item_t  reply_want;

    bit          send_steady;
    bit          recv_steady;
    int          hold_request;

    int          fail_count;
    int          items_sent;
    int          bytes_checked;
    int          acks_due;
    int          nacks_due;
    int          foreign_frames;
    int          stall_cycles;
    int          cycle_count;

    addressed_arm_command_frame_handler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void load_register(logic [acfh_pkg::CFG_IDX_W-1:0] idx,
                                          logic [7:0] val);
        case (idx)
            acfh_pkg::REG_STATION: cfg_model.station_addr = val;
            acfh_pkg::REG_SYNC:    cfg_model.sync_value   = val;
            acfh_pkg::REG_ACK:     cfg_model.ack_code     = val;
            acfh_pkg::REG_NACK:    cfg_model.nack_code    = val;
            acfh_pkg::REG_ARM:     cfg_model.arm_code     = val;
            acfh_pkg::REG_DISARM:  cfg_model.disarm_code  = val;
            default:     ;
        endcase
    endfunction

    function automatic void queue_reply(logic [7:0] status);
        logic [7:0]          b [acfh_pkg::FRAME_BYTES];
        acfh_pkg::out_item_t o;
        int                  k;
        b[acfh_pkg::POS_SYNC]    = cfg_model.sync_value;
        b[acfh_pkg::POS_STATION] = cfg_model.station_addr;
        b[acfh_pkg::POS_STATUS]  = status;
        b[acfh_pkg::POS_SEQ]     = rx_seq;
        b[acfh_pkg::POS_CHECK]   = b[acfh_pkg::POS_SYNC] ^ b[acfh_pkg::POS_STATION]
                                   ^ b[acfh_pkg::POS_STATUS] ^ b[acfh_pkg::POS_SEQ];
        for (k = 0; k < acfh_pkg::FRAME_BYTES; k++)
        begin
            o.tx_byte   = b[k];
            o.last_byte = (k == acfh_pkg::FRAME_BYTES - 1);
            o.arm_level = arm_model;
            reply_bytes_due.push_back(o);
        end
    endfunction

    function automatic void parse_rx_item(acfh_pkg::in_item_t it);
        if (it.cmd == acfh_pkg::EV_TIMEOUT)
        begin
            rx_phase = acfh_pkg::PH_HUNT;
            return;
        end
        case (rx_phase)
            acfh_pkg::PH_ADDR:
            begin
                rx_addr  = it.rx_byte;
                rx_xor   = rx_xor ^ it.rx_byte;
                rx_phase = acfh_pkg::PH_CMD;
            end
            acfh_pkg::PH_CMD:
            begin
                rx_cmd   = it.rx_byte;
                rx_xor   = rx_xor ^ it.rx_byte;
                rx_phase = acfh_pkg::PH_SEQ;
            end
            acfh_pkg::PH_SEQ:
            begin
                rx_seq   = it.rx_byte;
                rx_xor   = rx_xor ^ it.rx_byte;
                rx_phase = acfh_pkg::PH_CHK;
            end
            acfh_pkg::PH_CHK:
            begin
                rx_phase = acfh_pkg::PH_HUNT;
                if (rx_addr != cfg_model.station_addr)
                    foreign_frames++;
                else if (it.rx_byte != rx_xor)
                begin
                    nacks_due++;
                    queue_reply(cfg_model.nack_code);
                end
                // arm wins when both codes are equal
                else if (rx_cmd == cfg_model.arm_code)
                begin
                    arm_model = 1'b1;
                    acks_due++;
                    queue_reply(cfg_model.ack_code);
                end
                else if (rx_cmd == cfg_model.disarm_code)
                begin
                    arm_model = 1'b0;
                    acks_due++;
                    queue_reply(cfg_model.ack_code);
                end
                else
                begin
                    nacks_due++;
                    queue_reply(cfg_model.nack_code);
                end
            end
            default:
            begin
                if (it.rx_byte == cfg_model.sync_value)
                begin
                    rx_xor   = it.rx_byte;
                    rx_phase = acfh_pkg::PH_ADDR;
                end
                else
                    rx_phase = acfh_pkg::PH_HUNT;
            end
        endcase
    endfunction

    function automatic int pick_gap(bit steady);
        return steady ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic void flag_field(string field, int want, int got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    // valid is left high after an item so that a zero gap keeps it high
    task automatic send_item(input acfh_pkg::in_item_t it);
        int gap;
        gap = pick_gap(send_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
        begin
            stall_cycles++;
            @(posedge clk);
        end
        parse_rx_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        acfh_pkg::in_item_t it;
        it.cmd     = acfh_pkg::EV_BYTE;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_timeout();
        acfh_pkg::in_item_t it;
        it.cmd     = acfh_pkg::EV_TIMEOUT;
        it.rx_byte = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] op,
                              input logic [7:0] seq, input bit bad_check);
        logic [7:0] sync;
        logic [7:0] chk;
        sync = cfg_model.sync_value;
        chk  = sync ^ addr ^ op ^ seq;
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(sync);
        send_byte(addr);
        send_byte(op);
        send_byte(seq);
        send_byte(chk);
    endtask

    // drain all replies, then give the parser time to finish silent items
    task automatic settle();
        in_valid <= 1'b0;
        while (reply_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [acfh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        load_register(idx, val);
        @(posedge clk);
    endtask

    task automatic write_settings(input acfh_pkg::cfg_t c);
        write_reg(acfh_pkg::REG_STATION, c.station_addr);
        write_reg(acfh_pkg::REG_SYNC,    c.sync_value);
        write_reg(acfh_pkg::REG_ACK,     c.ack_code);
        write_reg(acfh_pkg::REG_NACK,    c.nack_code);
        write_reg(acfh_pkg::REG_ARM,     c.arm_code);
        write_reg(acfh_pkg::REG_DISARM,  c.disarm_code);
    endtask

    task automatic test_default_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_timeout();
        send_frame(acfh_pkg::RST_STATION, acfh_pkg::RST_ARM, 8'h00, 1'b0);
        send_frame(acfh_pkg::RST_STATION, acfh_pkg::RST_DISARM, 8'hFF, 1'b0);
        send_frame(acfh_pkg::RST_STATION, 8'h7E, 8'h11, 1'b0);
        send_frame(acfh_pkg::RST_STATION, acfh_pkg::RST_ARM, 8'h22, 1'b1);
        send_frame(8'h02, acfh_pkg::RST_ARM, 8'h33, 1'b0);
        // partial frame cut by a timeout
        send_byte(acfh_pkg::RST_SYNC);
        send_byte(acfh_pkg::RST_STATION);
        send_timeout();
        // sync value as the sequence byte is plain data
        send_frame(acfh_pkg::RST_STATION, acfh_pkg::RST_ARM, acfh_pkg::RST_SYNC, 1'b0);
        settle();
    endtask

    task automatic test_register_extremes();
        acfh_pkg::cfg_t c;
        c = '0;
        write_settings(c);
        write_reg(REG_SPARE_A, 8'hFF);
        write_reg(REG_SPARE_B, 8'h5A);
        send_frame(8'h00, 8'h00, 8'hA5, 1'b0);
        send_frame(8'h00, 8'h00, 8'h5A, 1'b1);
        settle();
        c = '1;
        write_settings(c);
        send_frame(8'hFF, 8'h00, 8'h01, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFE, 1'b0);
        settle();
        write_reg(REG_SPARE_A, 8'h00);
        write_reg(REG_SPARE_B, 8'hA5);
        send_frame(8'hFF, 8'hFF, 8'h80, 1'b0);
        settle();
    endtask

    task automatic test_random_traffic();
        acfh_pkg::cfg_t c;
        int             round;
        int             counted;
        int             pick;
        int             k;
        logic [7:0]     op;
        for (round = 0; round < 3; round++)
        begin
            c.station_addr = 8'($urandom);
            c.sync_value   = 8'($urandom);
            c.ack_code     = 8'($urandom);
            c.nack_code    = 8'($urandom);
            c.arm_code     = 8'($urandom);
            c.disarm_code  = ($urandom_range(0, 3) == 0) ? c.arm_code : 8'($urandom);
            write_settings(c);
            counted = 0;
            while (counted < RANDOM_ITEMS / 3)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_steady = !send_steady;
                if ($urandom_range(0, 7) == 0)
                    recv_steady = !recv_steady;
                pick = $urandom_range(0, 9);
                case (pick)
                    0:
                    begin
                        send_byte(8'($urandom));
                        counted += 1;
                        if (rx_phase != acfh_pkg::PH_HUNT)
                        begin
                            send_timeout();
                            counted += 1;
                        end
                    end
                    1:
                    begin
                        send_byte(cfg_model.sync_value);
                        k = $urandom_range(0, 3);
                        repeat (k) send_byte(8'($urandom));
                        send_timeout();
                        counted += k + 2;
                    end
                    2:
                    begin
                        send_frame(cfg_model.station_addr ^ 8'($urandom_range(1, 255)),
                                   8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
                        counted += acfh_pkg::FRAME_BYTES;
                    end
                    default:
                    begin
                        k = $urandom_range(0, 4);
                        op = (k < 2) ? cfg_model.arm_code :
                             (k < 4) ? cfg_model.disarm_code : 8'($urandom);
                        send_frame(cfg_model.station_addr, op, 8'($urandom),
                                   $urandom_range(0, 7) == 0);
                        counted += acfh_pkg::FRAME_BYTES;
                    end
                endcase
            end
            settle();
        end
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    // receiver blocks for a long stretch while frames keep coming
    task automatic test_backpressure();
        int n;
        send_steady  = 1'b1;
        hold_request = HOLD_CYCLES;
        for (n = 0; n < 8; n++)
            send_frame(cfg_model.station_addr,
                       n[0] ? cfg_model.disarm_code : cfg_model.arm_code,
                       8'($urandom), 1'b0);
        settle();
        send_steady = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cfg_model.station_addr = acfh_pkg::RST_STATION;
        cfg_model.sync_value   = acfh_pkg::RST_SYNC;
        cfg_model.ack_code     = acfh_pkg::RST_ACK;
        cfg_model.nack_code    = acfh_pkg::RST_NACK;
        cfg_model.arm_code     = acfh_pkg::RST_ARM;
        cfg_model.disarm_code  = acfh_pkg::RST_DISARM;
        rx_phase  = acfh_pkg::PH_HUNT;
        rx_addr   = '0;
        rx_cmd    = '0;
        rx_seq    = '0;
        rx_xor    = '0;
        arm_model = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frames();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        $display("sent %0d items over %0d register settings; checked %0d reply bytes",
                 items_sent, 6, bytes_checked);
        $display("%0d ack and %0d nack replies, %0d foreign frames, %0d input stall cycles",
                 acks_due, nacks_due, foreign_frames, stall_cycles);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // output side: random hold-off per item, plus one long hold on request
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
            begin
                gap = pick_gap(recv_steady);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_bytes_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected item, expected none, got %02h/%0d/%0d", $time,
                         out_item.tx_byte, out_item.last_byte, out_item.arm_level);
            end
            else
            begin
                reply_want = reply_bytes_due.pop_front();
                bytes_checked++;
                if (out_item.tx_byte !== reply_want.tx_byte)
                    flag_field("tx_byte", int'(reply_want.tx_byte),
                               int'(out_item.tx_byte));
                if (out_item.last_byte !== reply_want.last_byte)
                    flag_field("last_byte", int'(reply_want.last_byte),
                               int'(out_item.last_byte));
                if (out_item.arm_level !== reply_want.arm_level)
                    flag_field("arm_level", int'(reply_want.arm_level),
                               int'(out_item.arm_level));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles", $time, cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire

// File: addressed_arm_command_frame_handler.f
sv/acfh_pkg.sv
sv/acfh_parser.sv
sv/acfh_queue.sv
sv/acfh_tx.sv
sv/addressed_arm_command_frame_handler.sv
verif/testbench.sv
